@@ rtl/imuafp_pkg.sv @@
// ----------------------------------------------------------------------------
// imuafp_pkg
// shared types and constants of the imu angle frame parser
// ----------------------------------------------------------------------------
package imuafp_pkg;

    localparam logic [7:0] FRAME_HEAD = 8'h55;
    localparam logic [7:0] FRAME_TYPE = 8'h53;

    // byte positions within a frame
    localparam logic [3:0] POS_IDLE     = 4'd0;
    localparam logic [3:0] POS_TYPE     = 4'd1;
    localparam logic [3:0] POS_ROLL_LO  = 4'd2;
    localparam logic [3:0] POS_ROLL_HI  = 4'd3;
    localparam logic [3:0] POS_PITCH_LO = 4'd4;
    localparam logic [3:0] POS_PITCH_HI = 4'd5;
    localparam logic [3:0] POS_YAW_LO   = 4'd6;
    localparam logic [3:0] POS_YAW_HI   = 4'd7;
    localparam logic [3:0] POS_CHECK    = 4'd10;
    localparam logic [3:0] POS_DONE     = 4'd11;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_TYPE = 2'd1;
    localparam logic [1:0] ST_BAD_SUM  = 2'd2;

    localparam logic [1:0] CFG_ROLL_ZERO  = 2'd0;
    localparam logic [1:0] CFG_PITCH_ZERO = 2'd1;
    localparam logic [1:0] CFG_YAW_ZERO   = 2'd2;

    localparam int          QDEPTH = 2;
    localparam int          QPTR_W = 1;
    localparam int          QCNT_W = 2;
    localparam logic [1:0]  QFULL  = 2'd2;

    typedef struct packed {
        logic        type_ok;
        logic        sum_ok;
        logic [15:0] roll_raw;
        logic [15:0] pitch_raw;
        logic [15:0] yaw_raw;
    } t_frame_rec;

endpackage

@@ rtl/imu_angle_frame_parser_top.sv @@
// ----------------------------------------------------------------------------
// imu_angle_frame_parser_top
// parses 11-byte angle frames from a serial byte stream into offset angles
//
// channel   dir  fields (tdata / tuser, lowest bit first)
// s_axis    in   tdata: rx_byte[7:0]
// m_axis    out  tdata: roll_angle[16:0], pitch_angle[16:0], yaw_angle[15:0], 6'b0
//                tuser: frame_status[1:0]
// cfg       in   addr 0 roll_zero, 1 pitch_zero, 2 yaw_zero (16 bits each)
//
// one byte accepted per cycle while the queue has room; m_axis tvalid follows the
// acceptance of a frame's checksum byte, the frame passing the two-entry queue and
// the output register in that order
// intake stalls only when the queue is full, i.e. the output is stalled and
// two further frames have completed
// synchronous active-low reset clears frame sync, queue, offsets and angles
// ----------------------------------------------------------------------------
module imu_angle_frame_parser_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // rx_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [55:0] o_m_axis_tdata,   // roll_angle, pitch_angle, yaw_angle, pad
    output logic [1:0]  o_m_axis_tuser,   // frame_status
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_wdata
);
    import imuafp_pkg::*;

    logic               w_accept;
    logic               w_push;
    t_frame_rec         w_push_rec;
    logic               w_q_valid;
    logic               w_q_full;
    t_frame_rec         w_q_rec;
    logic               w_q_pop;
    logic [1:0]         w_status;
    logic signed [16:0] w_roll;
    logic signed [16:0] w_pitch;
    logic [15:0]        w_yaw;

    assign o_s_axis_tready = !w_q_full;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    imuafp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_byte   (i_s_axis_tdata),
        .o_push   (w_push),
        .o_rec    (w_push_rec)
    );

    imuafp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_rec   (w_push_rec),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_full  (w_q_full),
        .o_rec   (w_q_rec)
    );

    imuafp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_valid   (w_q_valid),
        .i_q_rec     (w_q_rec),
        .o_q_pop     (w_q_pop),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_status    (w_status),
        .o_roll      (w_roll),
        .o_pitch     (w_pitch),
        .o_yaw       (w_yaw)
    );

    assign o_m_axis_tdata = {6'b0, w_yaw, w_pitch, w_roll};
    assign o_m_axis_tuser = w_status;

    // status code 3 is never produced
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tuser != 2'd3))
        else $error("invalid frame status");

    // a queued frame reaches a free output register in the next cycle
    a_queue_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_q_valid && !o_m_axis_tvalid) |=> o_m_axis_tvalid)
        else $error("queued frame not forwarded");

    // a frame completed while the queue was empty is never lost
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_q_valid) |=> w_q_valid)
        else $error("completed frame not queued");

    // rejected frames leave the angles unchanged
    a_hold_angles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_q_pop && !(w_q_rec.type_ok && w_q_rec.sum_ok)) |=>
        ($stable(w_roll) && $stable(w_pitch) && $stable(w_yaw)))
        else $error("angles changed on rejected frame");

endmodule

@@ rtl/imuafp_front.sv @@
// ----------------------------------------------------------------------------
// imuafp_front
// byte intake: frame sync, running checksum and raw word capture
// ----------------------------------------------------------------------------
module imuafp_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic [7:0]            i_byte,
    output logic                  o_push,
    output imuafp_pkg::t_frame_rec o_rec
);
    import imuafp_pkg::*;

    logic [3:0]  r_pos;
    logic [3:0]  n_pos;
    logic [7:0]  r_sum;
    logic        r_type_ok;
    logic [15:0] r_roll;
    logic [15:0] r_pitch;
    logic [15:0] r_yaw;
    logic        w_in_frame;

    assign w_in_frame = (r_pos != POS_IDLE) && (r_pos != POS_DONE);

    always_comb begin
        n_pos = r_pos;
        if (i_accept) begin
            priority if (i_byte == FRAME_HEAD) begin
                n_pos = POS_TYPE;
            end else if (w_in_frame) begin
                n_pos = r_pos + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_IDLE;
        end else begin
            r_pos <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            if (i_byte == FRAME_HEAD) begin
                r_sum <= FRAME_HEAD;
            end else if (w_in_frame) begin
                r_sum <= r_sum + i_byte;
                unique case (r_pos)
                    POS_TYPE:     r_type_ok      <= (i_byte == FRAME_TYPE);
                    POS_ROLL_LO:  r_roll[7:0]    <= i_byte;
                    POS_ROLL_HI:  r_roll[15:8]   <= i_byte;
                    POS_PITCH_LO: r_pitch[7:0]   <= i_byte;
                    POS_PITCH_HI: r_pitch[15:8]  <= i_byte;
                    POS_YAW_LO:   r_yaw[7:0]     <= i_byte;
                    POS_YAW_HI:   r_yaw[15:8]    <= i_byte;
                    default: ;
                endcase
            end
        end
    end

    assign o_push = i_accept && (i_byte != FRAME_HEAD) && (r_pos == POS_CHECK);

    assign o_rec.type_ok   = r_type_ok;
    assign o_rec.sum_ok    = (r_sum == i_byte);
    assign o_rec.roll_raw  = r_roll;
    assign o_rec.pitch_raw = r_pitch;
    assign o_rec.yaw_raw   = r_yaw;

endmodule

@@ rtl/imuafp_queue.sv @@
// ----------------------------------------------------------------------------
// imuafp_queue
// two-entry queue of completed frames between intake and angle update
// ----------------------------------------------------------------------------
module imuafp_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  imuafp_pkg::t_frame_rec i_rec,
    input  logic                   i_pop,
    output logic                   o_valid,
    output logic                   o_full,
    output imuafp_pkg::t_frame_rec o_rec
);
    import imuafp_pkg::*;

    t_frame_rec        r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == QFULL);
    assign o_rec   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ rtl/imuafp_back.sv @@
// ----------------------------------------------------------------------------
// imuafp_back
// frame judgement, zero offsets, latest angles and output register
// ----------------------------------------------------------------------------
module imuafp_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [1:0]             i_cfg_addr,
    input  logic [15:0]            i_cfg_wdata,
    input  logic                   i_q_valid,
    input  imuafp_pkg::t_frame_rec i_q_rec,
    output logic                   o_q_pop,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [1:0]             o_status,
    output logic signed [16:0]     o_roll,
    output logic signed [16:0]     o_pitch,
    output logic [15:0]            o_yaw
);
    import imuafp_pkg::*;

    logic [15:0]        r_roll_zero;
    logic [15:0]        r_pitch_zero;
    logic [15:0]        r_yaw_zero;
    logic               r_valid;
    logic [1:0]         r_status;
    logic [1:0]         n_status;
    logic signed [16:0] r_roll;
    logic signed [16:0] r_pitch;
    logic [15:0]        r_yaw;
    logic signed [16:0] n_roll;
    logic signed [16:0] n_pitch;
    logic [15:0]        n_yaw;

    assign o_q_pop = i_q_valid && (!r_valid || i_ready);

    always_comb begin
        priority if (!i_q_rec.type_ok) begin
            n_status = ST_BAD_TYPE;
        end else if (!i_q_rec.sum_ok) begin
            n_status = ST_BAD_SUM;
        end else begin
            n_status = ST_OK;
        end
        n_roll  = $signed({1'b0, i_q_rec.roll_raw}) - $signed({1'b0, r_roll_zero});
        n_pitch = $signed({1'b0, i_q_rec.pitch_raw}) - $signed({1'b0, r_pitch_zero});
        // yaw wraps into one turn
        n_yaw   = i_q_rec.yaw_raw - r_yaw_zero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_roll_zero  <= '0;
            r_pitch_zero <= '0;
            r_yaw_zero   <= '0;
            r_valid      <= 1'b0;
            r_roll       <= '0;
            r_pitch      <= '0;
            r_yaw        <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_ROLL_ZERO:  r_roll_zero  <= i_cfg_wdata;
                    CFG_PITCH_ZERO: r_pitch_zero <= i_cfg_wdata;
                    CFG_YAW_ZERO:   r_yaw_zero   <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (o_q_pop) begin
                r_valid <= 1'b1;
                if (n_status == ST_OK) begin
                    r_roll  <= n_roll;
                    r_pitch <= n_pitch;
                    r_yaw   <= n_yaw;
                end
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_status <= n_status;
        end
    end

    assign o_valid  = r_valid;
    assign o_status = r_status;
    assign o_roll   = r_roll;
    assign o_pitch  = r_pitch;
    assign o_yaw    = r_yaw;

endmodule

@@ tb/tb_imu_angle_frame_parser_top.sv @@
// ----------------------------------------------------------------------------
// tb_imu_angle_frame_parser_top
// self-checking bench for the imu angle frame parser: serial bytes go in on
// s_axis, each completed frame is predicted from the bytes that were accepted
// and compared field by field with what leaves m_axis, over several offset
// settings and idle/stall mixes, including a long output hold-off
// ----------------------------------------------------------------------------
module tb_imu_angle_frame_parser_top;
    timeunit 1ns;
    timeprecision 1ps;

    import imuafp_pkg::*;

    localparam logic [1:0] CFG_NONE = 2'd3;

    typedef logic [7:0] t_frame [11];

    typedef struct packed {
        logic [1:0]  status;
        logic [16:0] roll;
        logic [16:0] pitch;
        logic [15:0] yaw;
    } t_angle_result;

    class angle_frame_scoreboard;
        logic [3:0]    byte_pos;
        logic [7:0]    frame_buf [11];
        logic [15:0]   roll_ofs, pitch_ofs, yaw_ofs;
        logic [17:0]   roll_val, pitch_val;
        logic [15:0]   yaw_val;
        t_angle_result pending_frames [$];
        int            errors;
        int            bytes_used;
        int            frames_seen;
        int            status_seen [3];

        function new();
            byte_pos    = POS_IDLE;
            roll_ofs    = '0;
            pitch_ofs   = '0;
            yaw_ofs     = '0;
            roll_val    = '0;
            pitch_val   = '0;
            yaw_val     = '0;
            errors      = 0;
            bytes_used  = 0;
            frames_seen = 0;
            status_seen = '{0, 0, 0};
        endfunction

        function void write_offset(logic [1:0] addr, logic [15:0] val);
            case (addr)
                CFG_ROLL_ZERO:  roll_ofs  = val;
                CFG_PITCH_ZERO: pitch_ofs = val;
                CFG_YAW_ZERO:   yaw_ofs   = val;
                default: ;
            endcase
        endfunction

        function void take_byte(logic [7:0] b);
            logic [7:0]    sum;
            t_angle_result r;
            if (b == FRAME_HEAD) begin
                frame_buf[0] = b;
                byte_pos     = POS_TYPE;
                bytes_used++;
                return;
            end
            if (byte_pos == POS_IDLE || byte_pos == POS_DONE) return;
            frame_buf[byte_pos] = b;
            byte_pos++;
            bytes_used++;
            if (byte_pos != POS_DONE) return;
            sum = '0;
            for (int i = 0; i < POS_CHECK; i++) sum += frame_buf[i];
            if (frame_buf[POS_TYPE] != FRAME_TYPE) begin
                r.status = ST_BAD_TYPE;
            end else if (sum != frame_buf[POS_CHECK]) begin
                r.status = ST_BAD_SUM;
            end else begin
                r.status  = ST_OK;
                roll_val  = {2'b00, frame_buf[POS_ROLL_HI], frame_buf[POS_ROLL_LO]}
                            - {2'b00, roll_ofs};
                pitch_val = {2'b00, frame_buf[POS_PITCH_HI], frame_buf[POS_PITCH_LO]}
                            - {2'b00, pitch_ofs};
                // yaw wraps into one turn, i.e. modulo 2^16
                yaw_val   = {frame_buf[POS_YAW_HI], frame_buf[POS_YAW_LO]} - yaw_ofs;
            end
            r.roll  = roll_val[16:0];
            r.pitch = pitch_val[16:0];
            r.yaw   = yaw_val;
            pending_frames.push_back(r);
        endfunction

        function void check_frame(logic [1:0] st, logic [55:0] data);
            t_angle_result want;
            if (pending_frames.size() == 0) begin
                $error("frame result with none pending: status %0d", st);
                errors++;
                return;
            end
            want = pending_frames.pop_front();
            frames_seen++;
            if (st != want.status) begin
                $error("frame_status: expected %0d, got %0d", want.status, st);
                errors++;
            end
            if (data[16:0] != want.roll) begin
                $error("roll_angle: expected %0d, got %0d",
                       $signed(want.roll), $signed(data[16:0]));
                errors++;
            end
            if (data[33:17] != want.pitch) begin
                $error("pitch_angle: expected %0d, got %0d",
                       $signed(want.pitch), $signed(data[33:17]));
                errors++;
            end
            if (data[49:34] != want.yaw) begin
                $error("yaw_angle: expected %0d, got %0d", want.yaw, data[49:34]);
                errors++;
            end
            if (want.status <= ST_BAD_SUM) status_seen[want.status]++;
        endfunction
    endclass

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata  = 8'h00;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [55:0] o_m_axis_tdata;   // roll_angle, pitch_angle, yaw_angle, pad
    logic [1:0]  o_m_axis_tuser;   // frame_status
    logic        i_cfg_we        = 1'b0;
    logic [1:0]  i_cfg_addr      = CFG_ROLL_ZERO;
    logic [15:0] i_cfg_wdata     = 16'h0000;

    int src_idle_pct  = 0;
    int dst_stall_pct = 0;
    int hold_left     = 0;

    angle_frame_scoreboard sb = new();

    imu_angle_frame_parser_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_m_axis_tready <= 1'b0;
            hold_left--;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= dst_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            sb.check_frame(o_m_axis_tuser, o_m_axis_tdata);
        end
    end

    function automatic logic [7:0] frame_sum(t_frame f);
        logic [7:0] s;
        s = '0;
        for (int i = 0; i < POS_CHECK; i++) s += f[i];
        return s;
    endfunction

    function automatic logic [7:0] data_byte();
        logic [7:0] b;
        do b = 8'($urandom); while (b == FRAME_HEAD);
        return b;
    endfunction

    function automatic t_frame good_frame();
        t_frame f;
        f[0]        = FRAME_HEAD;
        f[POS_TYPE] = FRAME_TYPE;
        for (int k = POS_ROLL_LO; k <= POS_YAW_LO; k += 2) begin
            case ($urandom_range(7))
                0: begin
                    f[k]     = 8'h00;
                    f[k + 1] = 8'h00;
                end
                1: begin
                    f[k]     = 8'hFF;
                    f[k + 1] = 8'hFF;
                end
                default: begin
                    f[k]     = data_byte();
                    f[k + 1] = data_byte();
                end
            endcase
        end
        f[8]         = data_byte();
        f[9]         = data_byte();
        f[POS_CHECK] = frame_sum(f);
        // a header value in the checksum slot would restart the frame
        while (f[POS_CHECK] == FRAME_HEAD) begin
            f[9] = f[9] + 8'd1;
            if (f[9] == FRAME_HEAD) f[9] = f[9] + 8'd1;
            f[POS_CHECK] = frame_sum(f);
        end
        return f;
    endfunction

    task automatic drive_byte(input logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.take_byte(b);
        @(negedge i_clk);
    endtask

    task automatic send_bytes(input t_frame f, input int count);
        for (int k = 0; k < count; k++) drive_byte(f[k]);
    endtask

    task automatic run_random(input int count);
        int     target;
        int     kind;
        t_frame f;
        target = sb.bytes_used + count;
        while (sb.bytes_used < target) begin
            f    = good_frame();
            kind = $urandom_range(99);
            if (kind < 66) begin
                send_bytes(f, 11);
            end else if (kind < 76) begin
                do f[POS_TYPE] = 8'($urandom);
                while (f[POS_TYPE] == FRAME_TYPE || f[POS_TYPE] == FRAME_HEAD);
                f[POS_CHECK] = $urandom_range(1) ? frame_sum(f) : data_byte();
                if (f[POS_CHECK] == FRAME_HEAD) f[POS_CHECK] = 8'h00;
                send_bytes(f, 11);
            end else if (kind < 86) begin
                do f[POS_CHECK] = data_byte(); while (f[POS_CHECK] == frame_sum(f));
                send_bytes(f, 11);
            end else if (kind < 93) begin
                // cut short, the next header lands inside this frame
                send_bytes(f, $urandom_range(1, 10));
            end else begin
                repeat ($urandom_range(1, 4)) drive_byte(8'($urandom));
            end
        end
    endtask

    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        while (sb.pending_frames.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] addr, input logic [15:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.write_offset(addr, val);
        @(negedge i_clk);
    endtask

    task automatic set_offsets(input logic [15:0] r, input logic [15:0] p,
                               input logic [15:0] y);
        write_reg(CFG_ROLL_ZERO, r);
        write_reg(CFG_PITCH_ZERO, p);
        write_reg(CFG_YAW_ZERO, y);
    endtask

    initial begin
        #4ms;
        $display("timeout: stream stopped making progress");
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        t_frame f;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // bytes with no frame open, full-scale frame, wrong type with bad sum
        drive_byte(8'h00);
        drive_byte(8'hFF);
        f = '{FRAME_HEAD, FRAME_TYPE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
              8'h00, 8'h00, 8'h00};
        f[POS_CHECK] = frame_sum(f);
        send_bytes(f, 11);
        f[POS_TYPE]    = 8'h00;
        f[POS_ROLL_LO] = 8'h00;
        f[POS_ROLL_HI] = 8'h00;
        send_bytes(f, 11);
        f = good_frame();
        send_bytes(f, 3);

        // long output hold-off while bytes keep coming at full rate
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        hold_left = 400;
        @(negedge i_clk);
        run_random(300);
        settle();

        set_offsets(16'hFFFF, 16'hFFFF, 16'hFFFF);
        write_reg(CFG_NONE, 16'h1234);
        src_idle_pct = 78;
        run_random(350);
        settle();

        set_offsets(16'($urandom), 16'($urandom), 16'($urandom));
        src_idle_pct  = 0;
        dst_stall_pct = 78;
        run_random(350);
        settle();

        set_offsets(16'h0001, 16'h8000, 16'h0000);
        src_idle_pct  = 14;
        dst_stall_pct = 14;
        run_random(350);

        i_s_axis_tvalid <= 1'b0;
        for (int w = 0; w < 20000 && sb.pending_frames.size() != 0; w++) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (sb.pending_frames.size() != 0) begin
            $error("%0d frame results never arrived", sb.pending_frames.size());
            sb.errors++;
        end

        $display("fed %0d frame bytes; checked %0d frames: %0d updated, %0d bad type, %0d bad sum",
                 sb.bytes_used, sb.frames_seen, sb.status_seen[ST_OK],
                 sb.status_seen[ST_BAD_TYPE], sb.status_seen[ST_BAD_SUM]);
        $display("four offset settings incl. extremes, idle/stall mixes and a 400-cycle hold");
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
